### hw/rtl/salru_pkg.sv
// Package for the set-associative LRU tag lookup core.
// Holds the field widths, configuration register indexes and reset values.
// Has no dependencies.
`default_nettype none

package salru_pkg;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int COUNT_W    = 32;
  localparam int WAY_OUT_W  = 3;
  localparam int CFG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int IDX_FLD_W  = (1 << CFG_W) - 1;
  localparam int NWAYS_W    = CFG_W + 1;

  localparam int MAX_WAYS_DEF  = 8;
  localparam int MAX_SETS_DEF  = 256;
  localparam int ADDR_BITS_DEF = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED   = 2'd2;

  localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd6;
  localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd8;
  localparam logic [CFG_W-1:0] WAYS_USED_RST   = 4'd8;

  function automatic int rank_w(input int n);
    rank_w = (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/salru_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Has no dependencies.
`default_nettype none

module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                                 clk,
  input  wire                                 we,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire [WIDTH-1:0]                     wdata,
  input  wire                                 re,
  input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hw/rtl/salru_set_logic.sv
// Hit detection, victim choice and recency update for one set.
// Depends on salru_pkg.
`default_nettype none

module salru_set_logic #(
  parameter int MAX_WAYS = salru_pkg::MAX_WAYS_DEF
) (
  input  wire [MAX_WAYS-1:0]                                    en,
  input  wire [MAX_WAYS-1:0]                                    valid,
  input  wire [MAX_WAYS*salru_pkg::rank_w(MAX_WAYS)-1:0]        rank,
  input  wire [MAX_WAYS*salru_pkg::TAG_W-1:0]                   tag_row,
  input  wire [salru_pkg::TAG_W-1:0]                            tag,
  output logic                                                  hit,
  output logic [salru_pkg::rank_w(MAX_WAYS)-1:0]                chosen,
  output logic [MAX_WAYS-1:0]                                   upd_valid,
  output logic [MAX_WAYS*salru_pkg::rank_w(MAX_WAYS)-1:0]       upd_rank,
  output logic [MAX_WAYS*salru_pkg::TAG_W-1:0]                  upd_tag_row
);

  localparam int RW = salru_pkg::rank_w(MAX_WAYS);
  localparam int TW = salru_pkg::TAG_W;

  logic [RW-1:0] rk [MAX_WAYS];
  logic [RW-1:0] hit_way;
  logic [RW-1:0] inv_way;
  logic [RW-1:0] lru_way;
  logic [RW-1:0] best;
  logic [RW-1:0] cur_rank;
  logic          any_inv;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      rk[w] = rank[w*RW +: RW];
    end

    hit     = 1'b0;
    hit_way = '0;
    any_inv = 1'b0;
    inv_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (en[w] && valid[w] && (tag_row[w*TW +: TW] == tag)) begin
        hit     = 1'b1;
        hit_way = RW'(w);
      end
      if (en[w] && !valid[w]) begin
        any_inv = 1'b1;
        inv_way = RW'(w);
      end
    end

    lru_way = '0;
    best    = rk[0];
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (en[w] && (rk[w] < best)) begin
        best    = rk[w];
        lru_way = RW'(w);
      end
    end

    if (hit) begin
      chosen = hit_way;
    end else if (any_inv) begin
      chosen = inv_way;
    end else begin
      chosen = lru_way;
    end

    cur_rank    = rk[chosen];
    upd_valid   = valid;
    upd_tag_row = tag_row;
    upd_rank    = rank;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (RW'(w) == chosen) begin
        upd_valid[w]           = 1'b1;
        upd_rank[w*RW +: RW]   = RW'(MAX_WAYS - 1);
        if (!hit) begin
          upd_tag_row[w*TW +: TW] = tag;
        end
      end else if (rk[w] > cur_rank) begin
        upd_rank[w*RW +: RW] = rk[w] - RW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/set_assoc_lru_tag_lookup_core.sv
// Set-associative tag lookup with LRU replacement and hit and miss counters.
// Pipeline: an accepted request reads its set row from the tag and metadata RAMs and
// the lookup stage registers the result; for a non power of two MAX_SETS an index stage
// computes the set index remainder first. A new request is accepted only after the set
// row is written back to the tag and metadata RAMs, which can wait on a stalled output.
// Reset: registers go to their reset values, counters clear, and a clearing pass over
// all MAX_SETS rows zeroes the metadata RAM while requests are stalled.
// Depends on salru_pkg, salru_ram and salru_set_logic.
`default_nettype none

module set_assoc_lru_tag_lookup_core #(
  parameter int MAX_WAYS  = salru_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS  = salru_pkg::MAX_SETS_DEF,
  parameter int ADDR_BITS = salru_pkg::ADDR_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   cfg_we,
  input  wire [salru_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [salru_pkg::CFG_W-1:0]            cfg_wdata,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire [salru_pkg::ADDR_W-1:0]           in_address,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic                                  out_hit,
  output logic [salru_pkg::WAY_OUT_W-1:0]       out_way,
  output logic [salru_pkg::COUNT_W-1:0]         out_hit_count,
  output logic [salru_pkg::COUNT_W-1:0]         out_miss_count
);

  localparam int RW  = salru_pkg::rank_w(MAX_WAYS);
  localparam int TW  = salru_pkg::TAG_W;
  localparam int AW  = salru_pkg::ADDR_W;
  localparam int CW  = salru_pkg::COUNT_W;
  localparam int XW  = salru_pkg::IDX_FLD_W;
  localparam int NW  = salru_pkg::NWAYS_W;
  localparam int SW  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int MW  = MAX_WAYS * (1 + RW);
  localparam bit SETS_POW2 = ((MAX_SETS & (MAX_SETS - 1)) == 0);
  localparam int SET_RECIP = (1 << XW) / MAX_SETS;
  localparam logic [AW-1:0] ADDR_MASK =
    (ADDR_BITS >= AW) ? {AW{1'b1}} : AW'((64'd1 << ADDR_BITS) - 64'd1);

  logic [salru_pkg::CFG_W-1:0] offset_bits_r;
  logic [salru_pkg::CFG_W-1:0] index_bits_r;
  logic [salru_pkg::CFG_W-1:0] ways_used_r;

  logic          clr_r;
  logic [SW-1:0] clr_cnt_r;
  logic          busy_r;
  logic          pre_r;
  logic          s1_r;
  logic [SW-1:0] set_r;
  logic [TW-1:0] tag_r;
  logic [XW-1:0] x_r;
  logic [XW-1:0] q_r;
  logic [CW-1:0] hits_r;
  logic [CW-1:0] misses_r;
  logic [CW-1:0] hits_nxt;
  logic [CW-1:0] misses_nxt;

  logic                   out_valid_r;
  logic                   out_hit_r;
  logic [salru_pkg::WAY_OUT_W-1:0] out_way_r;
  logic [CW-1:0]          out_hit_count_r;
  logic [CW-1:0]          out_miss_count_r;

  logic          in_acc;
  logic          out_free;
  logic          s1_done;
  logic [AW-1:0] addr_m;
  logic [AW-1:0] addr_sh;
  logic [XW-1:0] idx_mask;
  logic [XW-1:0] x_in;
  logic [31:0]   prod;
  logic [XW-1:0] q_in;
  logic [TW-1:0] tag_in;
  logic [SW-1:0] set_pow2;
  logic [XW-1:0] rem;
  logic [XW-1:0] rem_fix;
  logic [SW-1:0] set_div;
  logic          rd_en;
  logic [SW-1:0] rd_set;

  logic [NW-1:0]       nways;
  logic [MAX_WAYS-1:0] en;

  logic [TW*MAX_WAYS-1:0] tag_rd;
  logic [MW-1:0]          meta_rd;
  logic [MW-1:0]          meta_wr;
  logic                   meta_we;
  logic [SW-1:0]          meta_waddr;

  logic                      dec_hit;
  logic [RW-1:0]             dec_way;
  logic [MAX_WAYS-1:0]       upd_valid;
  logic [MAX_WAYS*RW-1:0]    upd_rank;
  logic [TW*MAX_WAYS-1:0]    upd_tag_row;
  logic [RW+2:0]             way_ext;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = clr_r || busy_r;
  assign out_free = !out_valid_r || !out_stall;
  assign s1_done  = s1_r && out_free;

  always_comb begin
    addr_m   = in_address & ADDR_MASK;
    addr_sh  = addr_m >> offset_bits_r;
    idx_mask = ~({XW{1'b1}} << index_bits_r);
    x_in     = addr_sh[XW-1:0] & idx_mask;
    tag_in   = addr_m >> ({1'b0, offset_bits_r} + {1'b0, index_bits_r});
    set_pow2 = SW'(x_in & XW'(MAX_SETS - 1));
    prod     = 32'(x_in) * 32'(SET_RECIP);
    q_in     = XW'(prod >> XW);
    rem      = XW'(32'(x_r) - 32'(q_r) * 32'(MAX_SETS));
    rem_fix  = (32'(rem) >= 32'(MAX_SETS)) ? XW'(32'(rem) - 32'(MAX_SETS)) : rem;
    set_div  = SW'(rem_fix);
    rd_en    = SETS_POW2 ? in_acc : pre_r;
    rd_set   = SETS_POW2 ? set_pow2 : set_div;
  end

  always_comb begin
    if (ways_used_r == '0) begin
      nways = NW'(1);
    end else if ({1'b0, ways_used_r} > NW'(MAX_WAYS)) begin
      nways = NW'(MAX_WAYS);
    end else begin
      nways = {1'b0, ways_used_r};
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      en[w] = (NW'(w) < nways);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_bits_r <= salru_pkg::OFFSET_BITS_RST;
      index_bits_r  <= salru_pkg::INDEX_BITS_RST;
      ways_used_r   <= salru_pkg::WAYS_USED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        salru_pkg::CFG_OFFSET_BITS: offset_bits_r <= cfg_wdata;
        salru_pkg::CFG_INDEX_BITS:  index_bits_r  <= cfg_wdata;
        salru_pkg::CFG_WAYS_USED:   ways_used_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + SW'(1);
      if (clr_cnt_r == SW'(MAX_SETS - 1)) begin
        clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pre_r  <= 1'b0;
      s1_r   <= 1'b0;
    end else begin
      pre_r <= in_acc && !SETS_POW2;
      if (in_acc) begin
        busy_r <= 1'b1;
      end else if (s1_done) begin
        busy_r <= 1'b0;
      end
      if (rd_en) begin
        s1_r <= 1'b1;
      end else if (s1_done) begin
        s1_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      tag_r <= tag_in;
      x_r   <= x_in;
      q_r   <= q_in;
    end
    if (rd_en) begin
      set_r <= rd_set;
    end
  end

  salru_ram #(
    .WIDTH(TW * MAX_WAYS),
    .DEPTH(MAX_SETS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (s1_done),
    .waddr(set_r),
    .wdata(upd_tag_row),
    .re   (rd_en),
    .raddr(rd_set),
    .rdata(tag_rd)
  );

  assign meta_we    = clr_r || s1_done;
  assign meta_waddr = clr_r ? clr_cnt_r : set_r;
  assign meta_wr    = clr_r ? '0 : {upd_rank, upd_valid};

  salru_ram #(
    .WIDTH(MW),
    .DEPTH(MAX_SETS)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wr),
    .re   (rd_en),
    .raddr(rd_set),
    .rdata(meta_rd)
  );

  salru_set_logic #(
    .MAX_WAYS(MAX_WAYS)
  ) u_set_logic (
    .en         (en),
    .valid      (meta_rd[MAX_WAYS-1:0]),
    .rank       (meta_rd[MW-1:MAX_WAYS]),
    .tag_row    (tag_rd),
    .tag        (tag_r),
    .hit        (dec_hit),
    .chosen     (dec_way),
    .upd_valid  (upd_valid),
    .upd_rank   (upd_rank),
    .upd_tag_row(upd_tag_row)
  );

  always_comb begin
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (dec_hit) begin
      if (hits_r != {CW{1'b1}}) begin
        hits_nxt = hits_r + CW'(1);
      end
    end else if (misses_r != {CW{1'b1}}) begin
      misses_nxt = misses_r + CW'(1);
    end
    way_ext = {3'b000, dec_way};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (s1_done) begin
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_done) begin
      out_hit_r        <= dec_hit;
      out_way_r        <= way_ext[2:0];
      out_hit_count_r  <= hits_nxt;
      out_miss_count_r <= misses_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hit        = out_hit_r;
  assign out_way        = out_way_r;
  assign out_hit_count  = out_hit_count_r;
  assign out_miss_count = out_miss_count_r;

  a_one_stage: assert property (@(posedge clk) disable iff (!rst_n)
    !(pre_r && s1_r))
    else $error("Index stage and lookup stage are both occupied.");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pre_r || s1_r))
    else $error("An accepted request did not enter the pipeline.");

  a_done_shows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_done |=> (out_valid_r && busy_r == 1'b0))
    else $error("A finished lookup did not reach the output register.");

  a_no_lookup_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> (!s1_r && !pre_r && !busy_r))
    else $error("A lookup is active during the clearing pass.");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_done && dec_hit && hits_r != {CW{1'b1}}) |=> (hits_r == $past(hits_r) + CW'(1)))
    else $error("Hit counter did not advance on a hit.");

endmodule

`default_nettype wire

### sim/set_assoc_lru_checker.sv
// Checker for the set-associative LRU tag lookup core: predicts each lookup
// and compares it with the result channel. Depends on salru_pkg.
module set_assoc_lru_checker (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              cfg_we,
  input  wire [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire [salru_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire                              in_valid,
  input  wire                              in_stall,
  input  wire [salru_pkg::ADDR_W-1:0]      in_address,
  input  wire                              out_valid,
  input  wire                              out_stall,
  input  wire                              out_hit,
  input  wire [salru_pkg::WAY_OUT_W-1:0]   out_way,
  input  wire [salru_pkg::COUNT_W-1:0]     out_hit_count,
  input  wire [salru_pkg::COUNT_W-1:0]     out_miss_count,
  output int                               mismatch_count,
  output int                               outstanding
);

  localparam int SETS = salru_pkg::MAX_SETS_DEF;
  localparam int WAYS = salru_pkg::MAX_WAYS_DEF;

  typedef struct packed {
    logic                            hit;
    logic [salru_pkg::WAY_OUT_W-1:0] way;
    logic [salru_pkg::COUNT_W-1:0]   hit_count;
    logic [salru_pkg::COUNT_W-1:0]   miss_count;
  } lookup_result_t;

  lookup_result_t                expected_lookups[$];
  logic [salru_pkg::CFG_W-1:0]   offset_bits_q;
  logic [salru_pkg::CFG_W-1:0]   index_bits_q;
  logic [salru_pkg::CFG_W-1:0]   ways_used_q;
  logic                          line_valid_q[SETS][WAYS];
  logic [salru_pkg::TAG_W-1:0]   line_tag_q[SETS][WAYS];
  logic [2:0]                    rank_q[SETS][WAYS];
  logic [salru_pkg::COUNT_W-1:0] hits_q;
  logic [salru_pkg::COUNT_W-1:0] misses_q;
  int                            errors;

  function automatic lookup_result_t predict_lookup(
      input logic [salru_pkg::ADDR_W-1:0] addr);
    lookup_result_t res;
    logic [63:0]    wide_addr;
    logic [63:0]    set_field;
    logic [63:0]    tag_field;
    logic [salru_pkg::TAG_W-1:0] tag;
    logic [2:0]     old_rank;
    logic           found;
    int             shift_amt;
    int             set_idx;
    int             nways;
    int             chosen;
    int             w;
    wide_addr = {32'd0, addr};
    nways = (ways_used_q == '0) ? 1 :
            ((int'(ways_used_q) > WAYS) ? WAYS : int'(ways_used_q));
    shift_amt = int'(offset_bits_q) + int'(index_bits_q);
    set_field = (wide_addr >> offset_bits_q) & ((64'd1 << index_bits_q) - 64'd1);
    set_idx = int'(set_field % SETS);
    tag_field = wide_addr >> shift_amt;
    tag = tag_field[salru_pkg::TAG_W-1:0];
    res.hit = 1'b0;
    chosen = 0;
    for (w = 0; w < nways; w++) begin
      if (!res.hit && line_valid_q[set_idx][w] && line_tag_q[set_idx][w] == tag) begin
        res.hit = 1'b1;
        chosen = w;
      end
    end
    if (res.hit) begin
      if (hits_q != '1) hits_q = hits_q + salru_pkg::COUNT_W'(1);
    end else begin
      if (misses_q != '1) misses_q = misses_q + salru_pkg::COUNT_W'(1);
      found = 1'b0;
      for (w = 0; w < nways; w++) begin
        if (!found && !line_valid_q[set_idx][w]) begin
          chosen = w;
          found = 1'b1;
        end
      end
      if (!found) begin
        chosen = 0;
        for (w = 1; w < nways; w++) begin
          if (rank_q[set_idx][w] < rank_q[set_idx][chosen]) chosen = w;
        end
      end
      line_valid_q[set_idx][chosen] = 1'b1;
      line_tag_q[set_idx][chosen] = tag;
    end
    old_rank = rank_q[set_idx][chosen];
    for (w = 0; w < WAYS; w++) begin
      if (w != chosen && rank_q[set_idx][w] > old_rank) begin
        rank_q[set_idx][w] = rank_q[set_idx][w] - 3'd1;
      end
    end
    rank_q[set_idx][chosen] = 3'(WAYS - 1);
    res.way = salru_pkg::WAY_OUT_W'(chosen);
    res.hit_count = hits_q;
    res.miss_count = misses_q;
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst_n) begin
      offset_bits_q = salru_pkg::OFFSET_BITS_RST;
      index_bits_q = salru_pkg::INDEX_BITS_RST;
      ways_used_q = salru_pkg::WAYS_USED_RST;
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid_q[s][w] = 1'b0;
          line_tag_q[s][w] = '0;
          rank_q[s][w] = '0;
        end
      end
      hits_q = '0;
      misses_q = '0;
      expected_lookups.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          salru_pkg::CFG_OFFSET_BITS: offset_bits_q = cfg_wdata;
          salru_pkg::CFG_INDEX_BITS:  index_bits_q = cfg_wdata;
          salru_pkg::CFG_WAYS_USED:   ways_used_q = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_lookups.push_back(predict_lookup(in_address));
      if (out_valid && !out_stall) begin
        if (expected_lookups.size() == 0) begin
          $display("%0t: result with no request outstanding: hit %0b way %0d", $time,
                   out_hit, out_way);
          errors++;
        end else begin
          want = expected_lookups.pop_front();
          if (out_hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b, actual %0b", $time, want.hit, out_hit);
            errors++;
          end
          if (out_way !== want.way) begin
            $display("%0t: way mismatch: expected %0d, actual %0d", $time, want.way, out_way);
            errors++;
          end
          if (out_hit_count !== want.hit_count) begin
            $display("%0t: hit_count mismatch: expected %0d, actual %0d", $time,
                     want.hit_count, out_hit_count);
            errors++;
          end
          if (out_miss_count !== want.miss_count) begin
            $display("%0t: miss_count mismatch: expected %0d, actual %0d", $time,
                     want.miss_count, out_miss_count);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    outstanding <= expected_lookups.size();
  end

endmodule

### sim/tb_set_assoc_lru_tag_lookup_core.sv
// Testbench top for set_assoc_lru_tag_lookup_core: drives address requests and
// register settings with random idling and gives the verdict.
// Depends on salru_pkg, the core RTL and set_assoc_lru_checker.
module tb_set_assoc_lru_tag_lookup_core;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 162;
  localparam int CW              = salru_pkg::CFG_W;
  localparam int AW              = salru_pkg::ADDR_W;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                cfg_we = 1'b0;
  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index = salru_pkg::CFG_OFFSET_BITS;
  logic [CW-1:0]                       cfg_wdata = '0;
  logic                                in_valid = 1'b0;
  logic [AW-1:0]                       in_address = '0;
  logic                                out_stall = 1'b0;
  logic                                in_stall;
  logic                                out_valid;
  logic                                out_hit;
  logic [salru_pkg::WAY_OUT_W-1:0]     out_way;
  logic [salru_pkg::COUNT_W-1:0]       out_hit_count;
  logic [salru_pkg::COUNT_W-1:0]       out_miss_count;
  int                                  mismatch_count;
  int                                  outstanding;

  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  bit   long_hold_req = 1'b0;
  int   sent = 0;
  logic [CW-1:0] cur_offset = salru_pkg::OFFSET_BITS_RST;
  logic [CW-1:0] cur_index = salru_pkg::INDEX_BITS_RST;
  logic [CW-1:0] cur_ways = salru_pkg::WAYS_USED_RST;

  int phase_offset[PHASES] = '{6, 0, 12, 15, 4, 2, 13};
  int phase_index[PHASES]  = '{8, 0, 8, 15, 12, 2, 1};
  int phase_ways[PHASES]   = '{8, 1, 0, 15, 3, 8, 2};
  int phase_tx[PHASES]     = '{31, 31, 31, 58, 58, 0, 0};
  int phase_rx[PHASES]     = '{58, 58, 58, 31, 31, 0, 0};

  set_assoc_lru_tag_lookup_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_way        (out_way),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count)
  );

  set_assoc_lru_checker lookup_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_address     (in_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_way        (out_way),
    .out_hit_count  (out_hit_count),
    .out_miss_count (out_miss_count),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic send_request(input logic [AW-1:0] addr);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(input logic [CW-1:0] off, input logic [CW-1:0] idx,
                            input logic [CW-1:0] ways);
    cfg_we <= 1'b1;
    cfg_index <= salru_pkg::CFG_OFFSET_BITS;
    cfg_wdata <= off;
    @(posedge clk);
    cfg_index <= salru_pkg::CFG_INDEX_BITS;
    cfg_wdata <= idx;
    @(posedge clk);
    cfg_index <= salru_pkg::CFG_WAYS_USED;
    cfg_wdata <= ways;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_offset = off;
    cur_index = idx;
    cur_ways = ways;
  endtask

  function automatic logic [AW-1:0] make_address(input int span,
                                                  input logic [31:0] tag_base);
    logic [63:0] composed;
    logic [63:0] set_sel;
    logic [31:0] tag_sel;
    int          shift_amt;
    shift_amt = int'(cur_offset) + int'(cur_index);
    set_sel = ($urandom_range(0, 9) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
    tag_sel = tag_base + $urandom_range(0, span);
    composed = {32'd0, tag_sel} << shift_amt;
    composed |= (set_sel & ((64'd1 << cur_index) - 64'd1)) << cur_offset;
    composed |= 64'($urandom) & ((64'd1 << cur_offset) - 64'd1);
    return composed[AW-1:0];
  endfunction

  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (long_hold_req && hold_left == 0) begin
        hold_left = 120;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  initial begin
    logic [31:0] tag_base;
    logic [31:0] addr;
    int          span;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct = phase_tx[0];
    rx_idle_pct = phase_rx[0];

    // Fill set 0 past its eight ways so the oldest line is evicted, then revisit.
    send_request(32'h0000_0000);
    send_request(32'h0000_0000);
    send_request(32'hFFFF_FFFF);
    send_request(32'hFFFF_FFC0);
    for (int t = 1; t <= 8; t++) send_request(32'(t) << 14);
    send_request(32'h0000_0000);
    send_request(32'h0001_4000);
    send_request(32'h8000_0000);
    send_request(32'h7FFF_FFFF);
    send_request(32'hAAAA_AAAA);
    send_request(32'h5555_5555);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        set_config(CW'(phase_offset[p]), CW'(phase_index[p]), CW'(phase_ways[p]));
      end
      tx_idle_pct = phase_tx[p];
      rx_idle_pct = phase_rx[p];
      tag_base = $urandom;
      span = ((cur_ways == '0) ? 1 :
              ((int'(cur_ways) > salru_pkg::MAX_WAYS_DEF) ? salru_pkg::MAX_WAYS_DEF :
               int'(cur_ways))) + 2;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if ($urandom_range(0, 4) == 0) addr = $urandom;
        else addr = make_address(span, tag_base);
        if ((p == 1 && i == 40) || (p == 4 && i == 60)) long_hold_req = 1'b1;
        send_request(addr);
      end
      drain_results();
    end

    repeat (10) @(posedge clk);
    $display("Sent %0d lookups over %0d register settings, including zero and oversized way",
             sent, PHASES);
    $display("counts, set indexes wider than storage, long result stalls and idle-free runs.");
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("** set_assoc_lru_tag_lookup_core: PASSED **");
    end else begin
      $display("** set_assoc_lru_tag_lookup_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Timeout with %0d results still outstanding.", outstanding);
    $display("** set_assoc_lru_tag_lookup_core: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/salru_pkg.sv
hw/rtl/salru_ram.sv
hw/rtl/salru_set_logic.sv
hw/rtl/set_assoc_lru_tag_lookup_core.sv
sim/set_assoc_lru_checker.sv
sim/tb_set_assoc_lru_tag_lookup_core.sv
